FILE: rtl/trpd_pkg.sv
// Shared types and constants for the run-length pixel decoder.
package trpd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned RUN_FLAG_BIT = 7;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAYSCALE = 2'd0,
    CFG_ALPHA     = 2'd1,
    CFG_TOTAL     = 2'd2
  } trpd_cfg_idx_t;

  // Byte positions within a pixel.
  localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_THIRD  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_FOURTH = 2'd3;

  typedef struct packed {
    logic               grayscale_mode;
    logic               alpha_present;
    logic [TOTAL_W-1:0] pixel_total;
  } trpd_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] repeat_count;
    logic              image_last;
  } trpd_result_t;

endpackage

FILE: rtl/tga_rle_pixel_decoder_unit.sv
// Top level of the run-length pixel decoder for Targa-style pixel data.
//
//   Channel  Handshake            Payload
//   -------  -------------------  --------------------------------------------
//   in       in_valid / in_stall  in_byte
//   out      out_valid/out_stall  red, green, blue, alpha, repeat_count,
//                                 image_last
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte is taken every cycle while in_stall is low; a completed pixel is
// registered in the output register, or in the skid entry if that is stalled.
// Reset is synchronous and active high; it clears the packet state, the pixel
// count and the configuration registers (pixel_total resets to one).
// A two-entry output buffer sits between the decoder and the out channel, so
// in_stall is high whenever both entries hold results.
// Configuration writes are always ready and apply from the next cycle.
module tga_rle_pixel_decoder_unit
  import trpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_byte,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    red,
  output logic [BYTE_W-1:0]    green,
  output logic [BYTE_W-1:0]    blue,
  output logic [BYTE_W-1:0]    alpha,
  output logic [BYTE_W-1:0]    repeat_count,
  output logic                 image_last,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOTAL_W-1:0]   cfg_data
);

  trpd_cfg_t    cfg;
  trpd_result_t res;
  trpd_result_t res_out;
  logic         res_valid;
  logic         buf_full;
  logic         accept;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  // The decoder takes a byte whenever the skid entry is free, so a byte that
  // completes a pixel always finds room for its result.
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  trpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  trpd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  trpd_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res_out)
  );

  assign red          = res_out.red;
  assign green        = res_out.green;
  assign blue         = res_out.blue;
  assign alpha        = res_out.alpha;
  assign repeat_count = res_out.repeat_count;
  assign image_last   = res_out.image_last;

endmodule

FILE: rtl/trpd_cfg_regs.sv
// Configuration registers of the run-length pixel decoder.
module trpd_cfg_regs
  import trpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [TOTAL_W-1:0]   wr_data,
  output trpd_cfg_t            cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grayscale_mode <= 1'b0;
      cfg.alpha_present  <= 1'b0;
      cfg.pixel_total    <= TOTAL_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        CFG_GRAYSCALE: cfg.grayscale_mode <= wr_data[0];
        CFG_ALPHA:     cfg.alpha_present  <= wr_data[0];
        CFG_TOTAL:     cfg.pixel_total    <= wr_data;
        default:       ;
      endcase
    end
  end

endmodule

FILE: rtl/trpd_core.sv
// Packet parsing, pixel assembly and image pixel counting.
module trpd_core
  import trpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  trpd_cfg_t         cfg,
  input  logic              accept,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              res_valid,
  output trpd_result_t      res
);

  logic                 expect_header, expect_header_next;
  logic                 run_packet, run_packet_next;
  logic [BYTE_W-1:0]    packet_left, packet_left_next;
  logic [PHASE_W-1:0]   byte_phase, byte_phase_next;
  logic [4*BYTE_W-1:0]  pixel_assembly, pixel_assembly_next;
  logic [TOTAL_W-1:0]   pixels_done, pixels_done_next;

  logic [PHASE_W-1:0]   last_phase;
  logic [4*BYTE_W-1:0]  merged;
  logic [TOTAL_W-1:0]   total_eff;
  logic [TOTAL_W-1:0]   remaining;
  logic [BYTE_W-1:0]    count;
  logic                 last;

  // Index of the final byte of a pixel in the current mode.
  always_comb begin
    if (cfg.grayscale_mode) begin
      last_phase = cfg.alpha_present ? PHASE_SECOND : PHASE_FIRST;
    end else begin
      last_phase = cfg.alpha_present ? PHASE_FOURTH : PHASE_THIRD;
    end
  end

  // Drop the incoming byte into its channel; bytes with no channel are lost.
  always_comb begin
    merged = pixel_assembly;
    if (cfg.grayscale_mode) begin
      if (byte_phase == PHASE_FIRST) begin
        merged[7:0] = pixel_assembly[7:0] | in_byte;
      end else if (byte_phase == PHASE_SECOND && cfg.alpha_present) begin
        merged[31:24] = pixel_assembly[31:24] | in_byte;
      end
    end else begin
      case (byte_phase)
        PHASE_FIRST:  merged[23:16] = pixel_assembly[23:16] | in_byte;
        PHASE_SECOND: merged[15:8]  = pixel_assembly[15:8] | in_byte;
        PHASE_THIRD:  merged[7:0]   = pixel_assembly[7:0] | in_byte;
        PHASE_FOURTH: begin
          if (cfg.alpha_present) begin
            merged[31:24] = pixel_assembly[31:24] | in_byte;
          end
        end
        default: ;
      endcase
    end
  end

  // Pixels left in the image; a zero total counts as one pixel, and a total
  // lowered to or below the count done leaves one pixel to finish the image.
  assign total_eff = (cfg.pixel_total == '0) ? TOTAL_W'(1) : cfg.pixel_total;
  assign remaining = (pixels_done < total_eff) ? (total_eff - pixels_done) : TOTAL_W'(1);

  always_comb begin
    if (run_packet) begin
      count = (remaining < TOTAL_W'(packet_left)) ? remaining[BYTE_W-1:0] : packet_left;
    end else begin
      count = BYTE_W'(1);
    end
  end

  assign last = (TOTAL_W'(count) >= remaining);

  always_comb begin
    expect_header_next  = expect_header;
    run_packet_next     = run_packet;
    packet_left_next    = packet_left;
    byte_phase_next     = byte_phase;
    pixel_assembly_next = pixel_assembly;
    pixels_done_next    = pixels_done;
    res_valid           = 1'b0;
    res.red             = merged[7:0];
    res.green           = merged[15:8];
    res.blue            = merged[23:16];
    res.alpha           = merged[31:24];
    res.repeat_count    = count;
    res.image_last      = last;

    if (accept) begin
      if (expect_header) begin
        run_packet_next     = in_byte[RUN_FLAG_BIT];
        packet_left_next    = {1'b0, in_byte[RUN_FLAG_BIT-1:0]} + BYTE_W'(1);
        expect_header_next  = 1'b0;
        byte_phase_next     = PHASE_FIRST;
        pixel_assembly_next = '0;
      end else if (byte_phase < last_phase) begin
        byte_phase_next     = byte_phase + PHASE_W'(1);
        pixel_assembly_next = merged;
      end else begin
        res_valid           = 1'b1;
        byte_phase_next     = PHASE_FIRST;
        pixel_assembly_next = '0;
        if (last) begin
          pixels_done_next   = '0;
          packet_left_next   = '0;
          expect_header_next = 1'b1;
        end else begin
          pixels_done_next = pixels_done + TOTAL_W'(count);
          if (run_packet) begin
            packet_left_next   = '0;
            expect_header_next = 1'b1;
          end else begin
            packet_left_next = packet_left - BYTE_W'(1);
            if (packet_left == BYTE_W'(1)) begin
              expect_header_next = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header  <= 1'b1;
      run_packet     <= 1'b0;
      packet_left    <= '0;
      byte_phase     <= PHASE_FIRST;
      pixel_assembly <= '0;
      pixels_done    <= '0;
    end else begin
      expect_header  <= expect_header_next;
      run_packet     <= run_packet_next;
      packet_left    <= packet_left_next;
      byte_phase     <= byte_phase_next;
      pixel_assembly <= pixel_assembly_next;
      pixels_done    <= pixels_done_next;
    end
  end

endmodule

FILE: rtl/trpd_out_buf.sv
// Result register with a skid stage so the input never waits on a fresh stall.
module trpd_out_buf
  import trpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  trpd_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output trpd_result_t out_data
);

  logic         main_valid;
  logic         skid_valid;
  trpd_result_t main_data;
  trpd_result_t skid_data;
  logic         pop;

  assign pop       = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end
    if (push && main_valid && !pop) begin
      skid_data <= push_data;
    end
  end

endmodule
